// ----- design/oplc_pkg.sv -----
// ----------------------------------------------------------------------------
// oplc_pkg
// Shared constants, register codes, configuration and control types of the
// oversampled piecewise linear calibrator.
// ----------------------------------------------------------------------------
package oplc_pkg;

	localparam int WINDOW_SAMPLES_DEF = 16;
	localparam int SHIFT_BITS_DEF     = 4;
	localparam int SAMPLE_BITS_DEF    = 12;

	localparam int MAX_POINTS     = 5;
	localparam int NUM_POINT_REGS = 5;
	localparam int SEG_W          = $clog2(NUM_POINT_REGS);

	localparam int SCALE_W    = 24;
	localparam int MV_W       = 16;
	localparam int RAW_OUT_W  = 12;
	localparam int PTS_W      = 3;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int DIVISOR_W  = 16;
	localparam int Y_W        = MV_W + FRAC_W + 2;

	localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(65536);
	localparam logic [PTS_W-1:0]   POINTS_RESET = PTS_W'(2);
	localparam logic [PTS_W-1:0]   POINTS_MIN   = PTS_W'(2);
	localparam logic [PTS_W-1:0]   POINTS_MAX   = PTS_W'(MAX_POINTS);
	localparam logic [Y_W-1:0]     Y_MAX        = {2'b00, {MV_W{1'b1}}, {FRAC_W{1'b0}}};
	localparam logic [Y_W-1:0]     ROUND_HALF   = Y_W'(32768);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_Q16  = 4'd0,
		REG_CAL_ENABLE = 4'd1,
		REG_POINTS     = 4'd2,
		REG_POINT_0    = 4'd3,
		REG_POINT_1    = 4'd4,
		REG_POINT_2    = 4'd5,
		REG_POINT_3    = 4'd6,
		REG_POINT_4    = 4'd7
	} cfg_reg_t;

	// Upper half is the actual value, lower half the measured value.
	typedef struct packed {
		logic [MV_W-1:0] act;
		logic [MV_W-1:0] meas;
	} cal_point_t;

	typedef struct packed {
		logic [SCALE_W-1:0]                    scale;
		logic                                  cal_en;
		logic [PTS_W-1:0]                      points;
		cal_point_t [NUM_POINT_REGS-1:0]       pts;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_ACCUM,
		ST_SCALE,
		ST_SEARCH,
		ST_PREP,
		ST_MAG,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FIX,
		ST_LIMIT,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_READ,
		OP_ACCUM,
		OP_SCALE,
		OP_SEARCH,
		OP_PREP,
		OP_MAG,
		OP_DIV_GO,
		OP_FIX,
		OP_LIMIT,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic   load_sample;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_full;
	} dp_status_t;

endpackage

// ----- design/oplc_ifs.sv -----
// ----------------------------------------------------------------------------
// oplc channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface oplc_sample_if #(parameter int SAMPLE_BITS = oplc_pkg::SAMPLE_BITS_DEF);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface oplc_result_if;
	import oplc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [RAW_OUT_W-1:0] averaged_raw;
	logic [MV_W-1:0]      voltage_mv;
	logic                 extrapolated;
	logic                 saturated;

	modport source (output valid, output averaged_raw, output voltage_mv,
		output extrapolated, output saturated, input ready);
	modport sink   (input valid, input averaged_raw, input voltage_mv,
		input extrapolated, input saturated, output ready);
endinterface

interface oplc_cfg_if;
	import oplc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/oversampled_piecewise_linear_calibrator.sv -----
// ----------------------------------------------------------------------------
// oversampled_piecewise_linear_calibrator
// Moving-window ADC averager with Q16 scaling and piecewise linear
// calibration to millivolts.
//
// Usage: sample_ch delivers one raw ADC conversion per beat. Each beat
// enters a ring of the last WINDOW_SAMPLES samples, and result_ch returns
// one beat with the averaged raw value, the calibrated voltage in
// millivolts and the extrapolated and saturated flags. cfg_ch writes the
// registers by index (0 scale, 1 enable, 2 point count, 3..7 points) and is
// always ready; write it only while no sample is in flight.
// A new sample is accepted only after the previous one has been emitted;
// most of its processing is done by the divider, which retires two
// quotient bits per cycle over the 52-bit interpolation product, with
// ten sequencer steps (read, accumulate, scale, search, prepare,
// magnitude, divider start, fix, limit, emit) around it.
// A finished result waits in the output register; the next sample is
// accepted and processed meanwhile and only its final step waits for the
// receiver. Reset clears the ring, its pointer and sum, and loads the
// register defaults.
// ----------------------------------------------------------------------------
module oversampled_piecewise_linear_calibrator #(
	parameter int WINDOW_SAMPLES = oplc_pkg::WINDOW_SAMPLES_DEF,
	parameter int SHIFT_BITS     = oplc_pkg::SHIFT_BITS_DEF,
	parameter int SAMPLE_BITS    = oplc_pkg::SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	oplc_sample_if.sink   sample_ch,
	oplc_result_if.source result_ch,
	oplc_cfg_if.sink      cfg_ch
);
	import oplc_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	oplc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	oplc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	oplc_datapath #(
		.WINDOW_SAMPLES (WINDOW_SAMPLES),
		.SHIFT_BITS     (SHIFT_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg          (cfg),
		.sample       (sample_ch.sample),
		.res_ready    (result_ch.ready),
		.res_valid    (result_ch.valid),
		.averaged_raw (result_ch.averaged_raw),
		.voltage_mv   (result_ch.voltage_mv),
		.extrapolated (result_ch.extrapolated),
		.saturated    (result_ch.saturated)
	);

endmodule

// ----- design/oplc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// oplc_cfg_regs
// Configuration register file: scale, calibration enable, point count and
// the five calibration points.
// ----------------------------------------------------------------------------
module oplc_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	oplc_cfg_if.sink         cfg_ch,
	output oplc_pkg::cfg_t   cfg
);
	import oplc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale  <= SCALE_RESET;
			cfg_q.cal_en <= 1'b0;
			cfg_q.points <= POINTS_RESET;
			cfg_q.pts[0] <= '0;
			cfg_q.pts[1] <= '1;
			cfg_q.pts[2] <= '0;
			cfg_q.pts[3] <= '0;
			cfg_q.pts[4] <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_SCALE_Q16:  cfg_q.scale  <= cfg_ch.data[SCALE_W-1:0];
				REG_CAL_ENABLE: cfg_q.cal_en <= cfg_ch.data[0];
				REG_POINTS:     cfg_q.points <= cfg_ch.data[PTS_W-1:0];
				REG_POINT_0:    cfg_q.pts[0] <= cfg_ch.data;
				REG_POINT_1:    cfg_q.pts[1] <= cfg_ch.data;
				REG_POINT_2:    cfg_q.pts[2] <= cfg_ch.data;
				REG_POINT_3:    cfg_q.pts[3] <= cfg_ch.data;
				REG_POINT_4:    cfg_q.pts[4] <= cfg_ch.data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- design/oplc_div.sv -----
// ----------------------------------------------------------------------------
// oplc_div
// Iterative unsigned divider, two restoring quotient bits per cycle,
// 16-bit divisor.
// ----------------------------------------------------------------------------
module oplc_div #(
	parameter int DIVIDEND_W = 52
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [DIVIDEND_W-1:0]            dividend,
	input  logic [oplc_pkg::DIVISOR_W-1:0]   divisor,
	output logic                             done,
	output logic [DIVIDEND_W-1:0]            quotient,
	output logic [oplc_pkg::DIVISOR_W-1:0]   remainder
);
	import oplc_pkg::*;

	localparam int STEPS = (DIVIDEND_W + 1) / 2;
	localparam int PAD_W = 2 * STEPS;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [PAD_W-1:0]     dq_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;

	logic [DIVISOR_W:0]   r1, r2, rm1, rm2;
	logic                 ge1, ge2;

	// Dividend bits shift out at the top while quotient bits shift in below.
	always_comb begin
		r1  = {rem_q, dq_q[PAD_W-1]};
		ge1 = r1 >= {1'b0, dvs_q};
		rm1 = ge1 ? r1 - {1'b0, dvs_q} : r1;
		r2  = {rm1[DIVISOR_W-1:0], dq_q[PAD_W-2]};
		ge2 = r2 >= {1'b0, dvs_q};
		rm2 = ge2 ? r2 - {1'b0, dvs_q} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= PAD_W'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			dq_q  <= {dq_q[PAD_W-3:0], ge1, ge2};
			rem_q <= rm2[DIVISOR_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = DIVIDEND_W'(dq_q);
	assign remainder = rem_q;

endmodule

// ----- design/oplc_datapath.sv -----
// ----------------------------------------------------------------------------
// oplc_datapath
// Sample ring and running sum, Q16 scaling, segment search, interpolation
// with the iterative divider, clamping, rounding and the result register.
// ----------------------------------------------------------------------------
module oplc_datapath #(
	parameter int WINDOW_SAMPLES = oplc_pkg::WINDOW_SAMPLES_DEF,
	parameter int SHIFT_BITS     = oplc_pkg::SHIFT_BITS_DEF,
	parameter int SAMPLE_BITS    = oplc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  oplc_pkg::dp_cmd_t                cmd,
	output oplc_pkg::dp_status_t             status,
	input  oplc_pkg::cfg_t                   cfg,
	input  logic [SAMPLE_BITS-1:0]           sample,
	input  logic                             res_ready,
	output logic                             res_valid,
	output logic [oplc_pkg::RAW_OUT_W-1:0]   averaged_raw,
	output logic [oplc_pkg::MV_W-1:0]        voltage_mv,
	output logic                             extrapolated,
	output logic                             saturated
);
	import oplc_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_SAMPLES);
	localparam int SUM_W = SAMPLE_BITS + PTR_W;
	localparam int AVG_W = SUM_W - SHIFT_BITS;
	localparam int X_W   = AVG_W + SCALE_W;
	localparam int XE_W  = (X_W > MV_W + FRAC_W) ? X_W : MV_W + FRAC_W;
	localparam int MAG_W = XE_W + MV_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_SAMPLES - 1);

	// Sample ring with per-entry valid bits; an unwritten entry reads as zero.
	logic [SAMPLE_BITS-1:0]    ring_mem [WINDOW_SAMPLES];
	logic [WINDOW_SAMPLES-1:0] ring_vld_q;
	logic [SAMPLE_BITS-1:0]    rd_data_q;
	logic [PTR_W-1:0]          ptr_q;
	logic [SUM_W-1:0]          sum_q;
	logic [SAMPLE_BITS-1:0]    sample_q;

	logic [XE_W-1:0]      x_q;
	logic                 extra_q;
	logic [MV_W-1:0]      m1_q, m2_q, a1_q, a2_q;
	logic                 flat_q;
	logic                 neg_q;
	logic [XE_W-1:0]      off_q;
	logic [MV_W-1:0]      da_q;
	logic [DIVISOR_W-1:0] d_q;
	logic [MAG_W-1:0]     mag_q;
	logic [MAG_W-1:0]     qc_q;
	logic                 neg_eff_q;
	logic [Y_W-1:0]       y_q;
	logic                 sat_q;

	logic                 res_valid_q;
	logic [RAW_OUT_W-1:0] raw_q;
	logic [MV_W-1:0]      mv_q;
	logic                 extra_out_q;
	logic                 sat_out_q;

	logic                 div_done;
	logic [MAG_W-1:0]     div_quot;
	logic [DIVISOR_W-1:0] div_rem;

	logic [SAMPLE_BITS-1:0] old_sample;
	logic [AVG_W-1:0]       avg;
	logic [X_W-1:0]         prod;

	logic [NUM_POINT_REGS-1:0] ge, le;
	logic [PTS_W-1:0]          n_eff;
	logic                      le_last;
	logic                      in_range;
	logic                      found;
	logic [SEG_W-1:0]          seg;
	logic [SEG_W-1:0]          seg_next;

	logic [XE_W-1:0] mstart;
	logic            off_neg;
	logic            da_neg;

	logic            neg_eff;
	logic [Y_W-1:0]  base;
	logic [Y_W-1:0]  y_next;
	logic            sat_next;
	logic [Y_W-1:0]  y_round;

	assign old_sample = ring_vld_q[ptr_q] ? rd_data_q : '0;
	assign avg        = sum_q[SUM_W-1:SHIFT_BITS];
	assign prod       = X_W'(avg) * X_W'(cfg.scale);

	// Segment search: the first segment whose ends bracket x, otherwise the
	// first or last segment for extrapolation.
	always_comb begin
		if (cfg.points < POINTS_MIN) begin
			n_eff = POINTS_MIN;
		end else if (cfg.points > POINTS_MAX) begin
			n_eff = POINTS_MAX;
		end else begin
			n_eff = cfg.points;
		end
		le_last = 1'b0;
		for (int k = 0; k < NUM_POINT_REGS; k++) begin
			ge[k] = x_q >= XE_W'({cfg.pts[k].meas, {FRAC_W{1'b0}}});
			le[k] = x_q <= XE_W'({cfg.pts[k].meas, {FRAC_W{1'b0}}});
			if (k == int'(n_eff) - 1) begin
				le_last = le[k];
			end
		end
		in_range = ge[0] && le_last;
		found    = 1'b0;
		seg      = '0;
		for (int k = 0; k < NUM_POINT_REGS - 1; k++) begin
			if (!found && in_range && (k + 1 < int'(n_eff)) && ge[k] && le[k+1]) begin
				found = 1'b1;
				seg   = SEG_W'(k);
			end
		end
		if (!found) begin
			seg = ge[0] ? SEG_W'(n_eff - PTS_W'(2)) : '0;
		end
		seg_next = SEG_W'(seg + 1'b1);
	end

	always_comb begin
		mstart  = XE_W'({m1_q, {FRAC_W{1'b0}}});
		off_neg = x_q < mstart;
		da_neg  = a2_q < a1_q;
	end

	// Interpolated value before the final clamp.
	always_comb begin
		neg_eff  = neg_q && (mag_q != '0);
		base     = Y_W'({a1_q, {FRAC_W{1'b0}}});
		y_next   = base;
		sat_next = 1'b0;
		if (!cfg.cal_en) begin
			if (XE_W'(x_q) > XE_W'(Y_MAX)) begin
				y_next   = Y_MAX;
				sat_next = 1'b1;
			end else begin
				y_next = Y_W'(x_q);
			end
		end else if (flat_q) begin
			y_next = base;
		end else if (neg_eff_q) begin
			if (qc_q > MAG_W'(base)) begin
				y_next   = '0;
				sat_next = 1'b1;
			end else begin
				y_next = base - Y_W'(qc_q);
			end
		end else begin
			if (qc_q > MAG_W'(Y_MAX)) begin
				y_next   = Y_MAX;
				sat_next = 1'b1;
			end else begin
				y_next = base + Y_W'(qc_q);
			end
		end
		y_round = y_q + ROUND_HALF;
	end

	oplc_div #(
		.DIVIDEND_W (MAG_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.op == OP_DIV_GO),
		.dividend  (mag_q),
		.divisor   (d_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q  <= '0;
			ptr_q       <= '0;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_ACCUM) begin
				ring_vld_q[ptr_q] <= 1'b1;
				sum_q <= sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
				ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
			end
			if (cmd.op == OP_EMIT) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= sample;
		end
		unique case (cmd.op)
			OP_READ: begin
				rd_data_q <= ring_mem[ptr_q];
			end
			OP_ACCUM: begin
				ring_mem[ptr_q] <= sample_q;
			end
			OP_SCALE: begin
				x_q <= XE_W'(prod);
			end
			OP_SEARCH: begin
				extra_q <= cfg.cal_en && !found;
				m1_q    <= cfg.pts[seg].meas;
				a1_q    <= cfg.pts[seg].act;
				m2_q    <= cfg.pts[seg_next].meas;
				a2_q    <= cfg.pts[seg_next].act;
			end
			OP_PREP: begin
				flat_q <= m2_q <= m1_q;
				d_q    <= m2_q - m1_q;
				neg_q  <= off_neg ^ da_neg;
				off_q  <= off_neg ? mstart - x_q : x_q - mstart;
				da_q   <= da_neg ? a1_q - a2_q : a2_q - a1_q;
			end
			OP_MAG: begin
				mag_q <= MAG_W'(off_q) * MAG_W'(da_q);
			end
			OP_FIX: begin
				// Rounds the quotient toward minus infinity when the slope term is negative.
				neg_eff_q <= neg_eff;
				qc_q      <= div_quot + MAG_W'(neg_eff && (div_rem != '0));
			end
			OP_LIMIT: begin
				y_q   <= y_next;
				sat_q <= sat_next;
			end
			OP_EMIT: begin
				raw_q       <= RAW_OUT_W'(avg);
				extra_out_q <= extra_q;
				if (y_q > Y_MAX) begin
					mv_q      <= '1;
					sat_out_q <= 1'b1;
				end else begin
					mv_q      <= y_round[FRAC_W +: MV_W];
					sat_out_q <= sat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign status.div_done = div_done;
	assign status.out_full = res_valid_q;

	assign res_valid    = res_valid_q;
	assign averaged_raw = raw_q;
	assign voltage_mv   = mv_q;
	assign extrapolated = extra_out_q;
	assign saturated    = sat_out_q;

endmodule

// ----- design/oplc_ctrl.sv -----
// ----------------------------------------------------------------------------
// oplc_ctrl
// Sequencer that walks one sample through the datapath steps.
// ----------------------------------------------------------------------------
module oplc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  oplc_pkg::dp_status_t   status,
	output oplc_pkg::dp_cmd_t      cmd
);
	import oplc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		cmd.load_sample = 1'b0;
		cmd.op          = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_sample = 1'b1;
					state_d         = ST_READ;
				end
			end
			ST_READ: begin
				cmd.op  = OP_READ;
				state_d = ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.op  = OP_ACCUM;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.op  = OP_SCALE;
				state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				cmd.op  = OP_SEARCH;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.op  = OP_PREP;
				state_d = ST_MAG;
			end
			ST_MAG: begin
				cmd.op  = OP_MAG;
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.op  = OP_DIV_GO;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.op  = OP_FIX;
				state_d = ST_LIMIT;
			end
			ST_LIMIT: begin
				cmd.op  = OP_LIMIT;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// Waits here while the previous result is still held.
				if (!status.out_full) begin
					cmd.op  = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
